// File: sv/tfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_pkg
// Shared constants, codes and controller/datapath types for the thermistor
// filter and table interpolation block.
// ----------------------------------------------------------------------------
package tfi_pkg;

    localparam int SENSORS       = 2;
    localparam int TABLE_ENTRIES = 32;
    localparam int SENS_W        = 1;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = SENS_W + IDX_W;
    localparam int DEPTH         = SENSORS * TABLE_ENTRIES;
    localparam int MODE_W        = 2;
    localparam int ADC_W         = 12;
    localparam int TEMP_W        = 10;
    localparam int OUT_ADC_W     = 16;
    localparam int PROD_W        = ADC_W + TEMP_W;
    localparam int DCNT_W        = $clog2(PROD_W + 1);
    localparam int FILTER_SHIFT  = 3;
    localparam int SUM_W         = ADC_W + FILTER_SHIFT;

    localparam logic [OUT_ADC_W-1:0] MISS_CODE = 16'hffff;

    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd3;

    // table read address selection
    localparam logic [2:0] RD_NONE = 3'd0;
    localparam logic [2:0] RD_ZERO = 3'd1;
    localparam logic [2:0] RD_LAST = 3'd2;
    localparam logic [2:0] RD_ONE  = 3'd3;
    localparam logic [2:0] RD_NEXT = 3'd4;

    // result register update
    localparam logic [2:0] RES_NONE   = 3'd0;
    localparam logic [2:0] RES_HIT    = 3'd1;
    localparam logic [2:0] RES_TEMP   = 3'd2;
    localparam logic [2:0] RES_INTERP = 3'd3;
    localparam logic [2:0] RES_ADC    = 3'd4;
    localparam logic [2:0] RES_MISS   = 3'd5;

    typedef struct packed {
        logic [ADC_W-1:0]  adc;
        logic [TEMP_W-1:0] temp;
    } entry_t;

    typedef struct packed {
        logic       capture;
        logic       filt_upd;
        logic [2:0] rd_sel;
        logic       save_prev;
        logic       mul_start;
        logic       mul_calc;
        logic       div_step;
        logic       wr_load;
        logic       wr_match;
        logic [2:0] res_sel;
        logic       out_load;
    } tfi_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              lt;
        logic              key_eq;
        logic              idx_last;
        logic              div_done;
        logic              out_free;
    } tfi_sts_t;

endpackage
`default_nettype wire

// File: sv/tfi_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface tfi_req_if;
    logic                      valid;
    logic                      ready;
    logic [tfi_pkg::MODE_W-1:0] mode;
    logic [tfi_pkg::SENS_W-1:0] sensor;
    logic [tfi_pkg::ADC_W-1:0]  sample;
    logic [tfi_pkg::IDX_W-1:0]  entry_index;
    logic [tfi_pkg::TEMP_W-1:0] temperature_key;
    logic [tfi_pkg::ADC_W-1:0]  adc_value_in;

    modport source (output valid, mode, sensor, sample, entry_index,
                    temperature_key, adc_value_in, input ready);
    modport sink (input valid, mode, sensor, sample, entry_index,
                  temperature_key, adc_value_in, output ready);
endinterface

interface tfi_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tfi_pkg::TEMP_W-1:0]    temperature;
    logic [tfi_pkg::OUT_ADC_W-1:0] table_adc;
    logic                         hit;

    modport source (output valid, temperature, table_adc, hit, input ready);
    modport sink (input valid, temperature, table_adc, hit, output ready);
endinterface
`default_nettype wire

// File: sv/thermistor_filter_interpolate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_filter_interpolate
// Per-sensor smoothing filter and calibration table interpolation.
// ----------------------------------------------------------------------------
// One request beat is taken at a time; each gives exactly one response beat.
// A sample beat updates the sensor's filter ((old*7 + sample)/8), then walks
// that sensor's table through the single read port of the table memory, one
// entry per cycle, and interpolates with one multiply and a bit-serial divider
// that yields one quotient bit per cycle. A sample ends soonest when the level
// clamps to an end of the table and takes longest when it lands in the last
// segment; set and get by temperature are bounded by the table walk. The
// response sits in an output register, so the next request is taken while it
// waits. Table entries are undefined until loaded; reading one before it is
// loaded gives no defined answer.
// ----------------------------------------------------------------------------
module thermistor_filter_interpolate (
    input  wire logic clk,
    input  wire logic rst_n,
    tfi_req_if.sink   req,
    tfi_rsp_if.source rsp
);
    import tfi_pkg::*;

    tfi_cmd_t cmd;
    tfi_sts_t sts;
    logic     in_ready;

    // drive the request ready from the sequencer
    assign req.ready = in_ready;

    tfi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tfi_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

    // one request in flight: no second beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    // a miss never reports a temperature
    a_miss_no_temp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.temperature == '0))
        else $error("temperature on a miss");

    // the miss code only comes with hit low
    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.table_adc == MISS_CODE) |-> !rsp.hit)
        else $error("miss code with hit");

    // a table value and a temperature never come together
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.table_adc != '0) |-> (rsp.temperature == '0))
        else $error("temperature and table value together");

endmodule
`default_nettype wire

// File: sv/tfi_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_datapath
// Filter registers, calibration table memory, scan compare, multiplier,
// bit-serial divider and output register.
// ----------------------------------------------------------------------------
module tfi_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    tfi_req_if.sink                req,
    tfi_rsp_if.source              rsp,
    input  wire tfi_pkg::tfi_cmd_t cmd,
    output tfi_pkg::tfi_sts_t      sts
);
    import tfi_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [SENS_W-1:0] sensor_reg;
    logic [ADC_W-1:0]  sample_reg;
    logic [IDX_W-1:0]  eidx_reg;
    logic [TEMP_W-1:0] key_reg;
    logic [ADC_W-1:0]  adcin_reg;

    logic [ADC_W-1:0]  filt_reg [SENSORS];
    logic [ADC_W-1:0]  level_reg;
    logic [ADC_W-1:0]  level_next;
    logic [SUM_W-1:0]  sum;

    entry_t            mem [DEPTH];
    entry_t            rd_data;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    logic [ADC_W-1:0]  prev_adc_reg;
    logic [TEMP_W-1:0] prev_temp_reg;
    logic [ADC_W-1:0]  off_reg;
    logic [TEMP_W-1:0] dtmag_reg;
    logic              dtneg_reg;
    logic [ADC_W-1:0]  da_reg;
    logic [TEMP_W-1:0] base_reg;

    logic [ADC_W-1:0]  rem_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [ADC_W:0]    rem_sh;
    logic              rem_ge;

    logic [TEMP_W-1:0]    res_temp_reg;
    logic [OUT_ADC_W-1:0] res_adc_reg;
    logic                 res_hit_reg;

    logic                 out_valid_reg;
    logic [TEMP_W-1:0]    out_temp_reg;
    logic [OUT_ADC_W-1:0] out_adc_reg;
    logic                 out_hit_reg;

    // capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= req.mode;
            sensor_reg <= req.sensor;
            sample_reg <= req.sample;
            eidx_reg   <= req.entry_index;
            key_reg    <= req.temperature_key;
            adcin_reg  <= req.adc_value_in;
        end
    end

    // level*7 + sample, then drop three bits
    assign sum = ({filt_reg[sensor_reg], {FILTER_SHIFT{1'b0}}} - SUM_W'(filt_reg[sensor_reg]))
                 + SUM_W'(sample_reg);
    assign level_next = sum[SUM_W-1:FILTER_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                filt_reg[i] <= '0;
            end
        end
        else if (cmd.filt_upd)
        begin
            filt_reg[sensor_reg] <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.filt_upd)
        begin
            level_reg <= level_next;
        end
    end

    // table memory: one write port, one registered read port
    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO: idx_next = '0;
            RD_LAST: idx_next = IDX_W'(TABLE_ENTRIES - 1);
            RD_ONE:  idx_next = IDX_W'(1);
            RD_NEXT: idx_next = idx_reg + IDX_W'(1);
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_sel != RD_NONE)
        begin
            idx_reg <= idx_next;
            rd_data <= mem[{sensor_reg, idx_next}];
        end
    end

    always_comb
    begin
        wr_en   = cmd.wr_load || cmd.wr_match;
        wr_addr = cmd.wr_load ? {sensor_reg, eidx_reg} : {sensor_reg, idx_reg};
        wr_data.adc  = adcin_reg;
        wr_data.temp = cmd.wr_load ? key_reg : rd_data.temp;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // segment operands
    always_ff @(posedge clk)
    begin
        if (cmd.save_prev)
        begin
            prev_adc_reg  <= rd_data.adc;
            prev_temp_reg <= rd_data.temp;
        end
        if (cmd.mul_start)
        begin
            off_reg   <= level_reg - prev_adc_reg;
            dtneg_reg <= rd_data.temp < prev_temp_reg;
            dtmag_reg <= (rd_data.temp < prev_temp_reg) ? prev_temp_reg - rd_data.temp
                                                         : rd_data.temp - prev_temp_reg;
            da_reg    <= rd_data.adc - prev_adc_reg;
            base_reg  <= prev_temp_reg;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[PROD_W-1]};
    assign rem_ge = rem_sh >= {1'b0, da_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_calc)
        begin
            rem_reg  <= '0;
            quo_reg  <= PROD_W'(off_reg * dtmag_reg);
            dcnt_reg <= DCNT_W'(PROD_W);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_ge ? ADC_W'(rem_sh - {1'b0, da_reg}) : rem_sh[ADC_W-1:0];
            quo_reg  <= {quo_reg[PROD_W-2:0], rem_ge};
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        case (cmd.res_sel)
            RES_HIT:
            begin
                res_temp_reg <= '0;
                res_adc_reg  <= '0;
                res_hit_reg  <= 1'b1;
            end
            RES_TEMP:
            begin
                res_temp_reg <= rd_data.temp;
                res_adc_reg  <= '0;
                res_hit_reg  <= 1'b1;
            end
            RES_INTERP:
            begin
                res_temp_reg <= dtneg_reg ? base_reg - quo_reg[TEMP_W-1:0]
                                          : base_reg + quo_reg[TEMP_W-1:0];
                res_adc_reg  <= '0;
                res_hit_reg  <= 1'b1;
            end
            RES_ADC:
            begin
                res_temp_reg <= '0;
                res_adc_reg  <= OUT_ADC_W'(rd_data.adc);
                res_hit_reg  <= 1'b1;
            end
            RES_MISS:
            begin
                res_temp_reg <= '0;
                res_adc_reg  <= (mode_reg == MODE_GET) ? MISS_CODE : '0;
                res_hit_reg  <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_temp_reg <= res_temp_reg;
            out_adc_reg  <= res_adc_reg;
            out_hit_reg  <= res_hit_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.temperature = out_temp_reg;
    assign rsp.table_adc   = out_adc_reg;
    assign rsp.hit         = out_hit_reg;

    assign sts.mode     = mode_reg;
    assign sts.lt       = level_reg < rd_data.adc;
    assign sts.key_eq   = rd_data.temp == key_reg;
    assign sts.idx_last = idx_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign sts.div_done = dcnt_reg == '0;
    assign sts.out_free = !out_valid_reg || rsp.ready;

endmodule
`default_nettype wire

// File: sv/tfi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_ctrl
// Sequencer: dispatch by mode, walk the table, run multiply and divide,
// hand the result to the output register.
// ----------------------------------------------------------------------------
module tfi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tfi_pkg::tfi_sts_t sts,
    output tfi_pkg::tfi_cmd_t      cmd
);
    import tfi_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_CHK0 = 4'd2;
    localparam logic [3:0] S_CHKL = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_SRCH = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.mode)
                    MODE_SAMPLE:
                    begin
                        cmd.filt_upd = 1'b1;
                        cmd.rd_sel   = RD_ZERO;
                        state_next   = S_CHK0;
                    end
                    MODE_LOAD:
                    begin
                        cmd.wr_load = 1'b1;
                        cmd.res_sel = RES_HIT;
                        state_next  = S_DONE;
                    end
                    default:
                    begin
                        cmd.rd_sel = RD_ZERO;
                        state_next = S_SRCH;
                    end
                endcase
            end
            S_CHK0:
            begin
                if (sts.lt)
                begin
                    cmd.res_sel = RES_TEMP;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    cmd.rd_sel    = RD_LAST;
                    state_next    = S_CHKL;
                end
            end
            S_CHKL:
            begin
                if (!sts.lt)
                begin
                    cmd.res_sel = RES_TEMP;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_ONE;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.lt)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    cmd.rd_sel    = RD_NEXT;
                end
            end
            S_MUL:
            begin
                cmd.mul_calc = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIN:
            begin
                cmd.res_sel = RES_INTERP;
                state_next  = S_DONE;
            end
            S_SRCH:
            begin
                if (sts.key_eq)
                begin
                    cmd.wr_match = sts.mode == MODE_SET;
                    cmd.res_sel  = (sts.mode == MODE_SET) ? RES_HIT : RES_ADC;
                    state_next   = S_DONE;
                end
                else if (sts.idx_last)
                begin
                    cmd.res_sel = RES_MISS;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: tb/sv/tb_thermistor_filter_interpolate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermistor_filter_interpolate
// Self-checking bench for the thermistor filter and table interpolation block.
// ----------------------------------------------------------------------------
// Tables are loaded in full before any sample or lookup touches them, so no
// entry is ever read unwritten. A small scoreboard class mirrors the filter and
// table state, predicts each response when its request beat is taken, and
// compares response beats in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_thermistor_filter_interpolate;
    import tfi_pkg::*;

    typedef struct packed {
        logic [TEMP_W-1:0]    temperature;
        logic [OUT_ADC_W-1:0] table_adc;
        logic                 hit;
    } reading_t;

    class conversion_scoreboard;
        logic [ADC_W-1:0]  level [SENSORS];
        logic [ADC_W-1:0]  adc_tab [SENSORS][TABLE_ENTRIES];
        logic [TEMP_W-1:0] temp_tab [SENSORS][TABLE_ENTRIES];
        reading_t          pending [$];
        int                mismatches;
        int                checked;

        function new();
            foreach (level[s])
                level[s] = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        // Piecewise linear lookup of a filtered level in one sensor's table.
        function logic [TEMP_W-1:0] level_to_degrees(int s, int lvl);
            int off;
            int dt;
            int da;
            if (lvl < adc_tab[s][0])
                return temp_tab[s][0];
            if (lvl >= adc_tab[s][TABLE_ENTRIES-1])
                return temp_tab[s][TABLE_ENTRIES-1];
            for (int i = 1; i < TABLE_ENTRIES; i++)
            begin
                if (lvl < adc_tab[s][i])
                begin
                    off = lvl - int'(adc_tab[s][i-1]);
                    dt = int'(temp_tab[s][i]) - int'(temp_tab[s][i-1]);
                    da = int'(adc_tab[s][i]) - int'(adc_tab[s][i-1]);
                    return TEMP_W'(int'(temp_tab[s][i-1]) + (off * dt) / da);
                end
            end
            return '0;
        endfunction

        function int find_key(int s, logic [TEMP_W-1:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (temp_tab[s][i] == key)
                    return i;
            return -1;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, int s, logic [ADC_W-1:0] smp,
                                   int idx, logic [TEMP_W-1:0] key, logic [ADC_W-1:0] av);
            reading_t r;
            int pos;
            r = '0;
            case (mode)
                MODE_SAMPLE:
                begin
                    level[s] = ADC_W'((int'(level[s]) * 7 + int'(smp)) / 8);
                    r.temperature = level_to_degrees(s, level[s]);
                    r.hit = 1'b1;
                end
                MODE_LOAD:
                begin
                    adc_tab[s][idx] = av;
                    temp_tab[s][idx] = key;
                    r.hit = 1'b1;
                end
                MODE_SET:
                begin
                    pos = find_key(s, key);
                    if (pos >= 0)
                    begin
                        adc_tab[s][pos] = av;
                        r.hit = 1'b1;
                    end
                end
                default:
                begin
                    pos = find_key(s, key);
                    if (pos >= 0)
                    begin
                        r.table_adc = OUT_ADC_W'(adc_tab[s][pos]);
                        r.hit = 1'b1;
                    end
                    else
                        r.table_adc = MISS_CODE;
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected response %p", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %0d: expected temp %0d adc %h hit %b, got temp %0d adc %h hit %b",
                             checked, want.temperature, want.table_adc, want.hit,
                             got.temperature, got.table_adc, got.hit);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    tfi_req_if req ();
    tfi_rsp_if rsp ();

    thermistor_filter_interpolate dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    conversion_scoreboard board;
    int  cycle_count;
    bit  stimulus_done;
    int  n_samples, n_loads, n_sets, n_gets, n_misses;
    localparam int CYCLE_LIMIT = 1000000;

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // Mostly short gaps, sometimes a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Note each accepted request; check each accepted response.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
                board.note_request(req.mode, req.sensor, req.sample, req.entry_index,
                                   req.temperature_key, req.adc_value_in);
            if (rsp.valid && rsp.ready)
                board.check_reading({rsp.temperature, rsp.table_adc, rsp.hit});
        end
    end

    // Response side: stall ready at random, with quiet stretches in between.
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((cycle_count / 500) % 3 == 2)
                rsp.ready <= 1'b1;
            else if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    // Send one request beat and hold it until taken, then, if idle is set, idle a random gap.
    task automatic send_beat(logic [MODE_W-1:0] mode, logic s, logic [ADC_W-1:0] smp,
                             logic [IDX_W-1:0] idx, logic [TEMP_W-1:0] key,
                             logic [ADC_W-1:0] av, bit idle);
        int g;
        req.valid <= 1'b1;
        req.mode <= mode;
        req.sensor <= s;
        req.sample <= smp;
        req.entry_index <= idx;
        req.temperature_key <= key;
        req.adc_value_in <= av;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        case (mode)
            MODE_SAMPLE: n_samples++;
            MODE_LOAD:   n_loads++;
            MODE_SET:    n_sets++;
            default:     n_gets++;
        endcase
        g = idle ? gap_len() : 0;
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g)
                @(posedge clk);
        end
    endtask

    // Fill one sensor's table with ascending ADC values; temps rise or fall.
    // Wide steps keep the top of the range reachable, narrow ones test slopes.
    task automatic load_table(logic s, bit extremes);
        int a;
        int t;
        int dir;
        a = extremes ? 0 : $urandom_range(0, 200);
        t = $urandom_range(0, 1023);
        dir = $urandom_range(0, 1);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (extremes && i == TABLE_ENTRIES - 1)
                a = 4095;
            send_beat(MODE_LOAD, s, '0, IDX_W'(i), TEMP_W'(t), ADC_W'(a), 1'b1);
            a = a + $urandom_range(1, extremes ? 132 : 140);
            if (a > 4094 - (TABLE_ENTRIES - i))
                a = 4094 - (TABLE_ENTRIES - i) + 1;
            t = dir ? t + $urandom_range(0, 60) : t - $urandom_range(0, 60);
            if (t > 1023)
                t = 1023;
            if (t < 0)
                t = 0;
        end
    endtask

    // Drop valid, let the last taken beat reach the scoreboard, then wait out
    // every pending response.
    task automatic wait_drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    task automatic random_beat();
        logic s;
        int m;
        logic [TEMP_W-1:0] key;
        s = 1'($urandom_range(0, 1));
        m = $urandom_range(0, 9);
        // Keys mostly hit an existing entry, sometimes anything.
        if ($urandom_range(0, 2) == 0)
            key = TEMP_W'($urandom_range(0, 1023));
        else
            key = board.temp_tab[s][$urandom_range(0, TABLE_ENTRIES - 1)];
        if (m < 6)
            send_beat(MODE_SAMPLE, s, ($urandom_range(0, 4) == 0) ?
                      ADC_W'($urandom_range(0, 1) ? 4095 : 0) : ADC_W'($urandom()),
                      IDX_W'($urandom()), TEMP_W'($urandom()), ADC_W'($urandom()), 1'b1);
        else if (m == 6)
            send_beat(MODE_LOAD, s, ADC_W'($urandom()), IDX_W'($urandom()),
                      TEMP_W'($urandom()), ADC_W'($urandom()), 1'b1);
        else if (m == 7)
            send_beat(MODE_SET, s, ADC_W'($urandom()), IDX_W'($urandom()), key,
                      ADC_W'($urandom()), 1'b1);
        else
        begin
            if (board.find_key(s, key) < 0)
                n_misses++;
            send_beat(MODE_GET, s, ADC_W'($urandom()), IDX_W'($urandom()), key,
                      ADC_W'($urandom()), 1'b1);
        end
    endtask

    // Stimulus
    initial
    begin
        board = new();
        stimulus_done = 1'b0;
        req.valid <= 1'b0;
        req.mode <= MODE_SAMPLE;
        req.sensor <= 1'b0;
        req.sample <= '0;
        req.entry_index <= '0;
        req.temperature_key <= '0;
        req.adc_value_in <= '0;
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-range tables, samples at both ends of the range, all modes, misses.
        load_table(1'b0, 1'b1);
        load_table(1'b1, 1'b1);
        send_beat(MODE_SAMPLE, 1'b0, 12'd0, '0, '0, '0, 1'b0);
        send_beat(MODE_SAMPLE, 1'b0, 12'd4095, '1, '1, '1, 1'b0);
        repeat (6)
            send_beat(MODE_SAMPLE, 1'b1, 12'd4095, '0, '0, '0, 1'b0);
        send_beat(MODE_SAMPLE, 1'b1, 12'd0, '0, '0, '0, 1'b0);
        send_beat(MODE_GET, 1'b0, '0, '0, board.temp_tab[0][TABLE_ENTRIES-1], '0, 1'b0);
        send_beat(MODE_GET, 1'b1, '0, '0, board.temp_tab[1][0], '0, 1'b0);
        send_beat(MODE_SET, 1'b0, '0, '0, board.temp_tab[0][5], 12'hfff, 1'b0);
        send_beat(MODE_GET, 1'b0, '0, '0, board.temp_tab[0][5], '0, 1'b0);
        send_beat(MODE_GET, 1'b1, '0, '0, board.temp_tab[1][0] ^ 10'h3ff, '0, 1'b0);
        send_beat(MODE_SET, 1'b1, '0, '0, board.temp_tab[1][0] ^ 10'h3ff, 12'hfff, 1'b0);
        // Pause until every pending response has come back.
        wait_drain();

        // Random: reload tables now and then with fresh curves.
        for (int k = 0; k < 500; k++)
        begin
            if (k % 125 == 0)
            begin
                load_table(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                if (k == 250)
                    wait_drain();
            end
            random_beat();
        end
        wait_drain();
        stimulus_done = 1'b1;
    end

    // End of run and watchdog.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("FAIL");
                $finish;
            end
            if (stimulus_done && board.pending.size() == 0)
            begin
                repeat (80)
                    @(posedge clk);
                $display("Covered %0d samples, %0d loads, %0d sets, %0d gets (%0d misses)",
                         n_samples, n_loads, n_sets, n_gets, n_misses);
                $display("Responses checked: %0d, mismatches: %0d",
                         board.checked, board.mismatches);
                if (board.mismatches == 0 && board.pending.size() == 0)
                    $display("PASS");
                else
                    $display("FAIL");
                $finish;
            end
        end
    end
endmodule
